/* rtl/core/lspg_pkg.sv */
`timescale 1ns / 1ps

package lspg_pkg;

   localparam int IDX_W   = 6;
   localparam int COLOR_W = 24;
   localparam int POS_W   = 7;

   localparam logic [COLOR_W-1:0] COLOR_OFF   = 24'h000000;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;

   localparam logic [15:0] FRAMES_PER_EFFECT_RESET = 16'd400;

   typedef enum logic [1:0] {
      EFFECT_CYCLE  = 2'd0,
      EFFECT_BLINK  = 2'd1,
      EFFECT_BOUNCE = 2'd2,
      EFFECT_SPIN   = 2'd3
   } effect_type;

   // how the back end paints one frame
   typedef enum logic [1:0] {
      PAINT_FILL   = 2'd0,
      PAINT_BOUNCE = 2'd1,
      PAINT_SPIN   = 2'd2
   } paint_type;

   typedef struct packed {
      paint_type          paint;
      effect_type         effect;
      logic [COLOR_W-1:0] color;
      logic [POS_W-1:0]   pos;
   } frame_desc_type;

   function automatic logic [COLOR_W-1:0] palette(input logic [2:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = 24'hFF0000;
         3'd1:    c = 24'hFF7F00;
         3'd2:    c = 24'hFFFF00;
         3'd3:    c = 24'h00FF00;
         3'd4:    c = 24'h00FFFF;
         3'd5:    c = 24'h0000FF;
         3'd6:    c = 24'h7F007F;
         default: c = 24'hFF007F;
      endcase
      return c;
   endfunction

endpackage

/* rtl/core/led_strip_pattern_generator.sv */
`timescale 1ns / 1ps
// channel  direction  beat
// req      in         blank: 1 = all-off frame, 0 = advance one frame
// rsp      out        led_index, color, last_led, active_effect (one per LED)
// csr      in         frames_per_effect
//
// each request beat yields LED_TOTAL response beats, one per cycle while rsp is
// not stalled; the back end's LED counter sets that count.
// the front end classifies a request in its accept cycle and queues a frame
// descriptor (two deep), so requests keep flowing while a frame drains.
// reset is synchronous; all animation state returns to its start values.
// a stalled rsp holds its beat and the back end stops; the front end stalls
// only when the queue is full.
module led_strip_pattern_generator #(
   parameter int LED_TOTAL = 18,
   parameter int SEGMENTS  = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_blank,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_led_index,
   output logic [23:0] rsp_color,
   output logic        rsp_last_led,
   output logic [1:0]  rsp_active_effect,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_frames_per_effect
);
   import lspg_pkg::*;

   logic           push_valid, push_ready, pop_valid, pop_ready;
   frame_desc_type push_desc, pop_desc;

   lspg_front #(.LED_TOTAL(LED_TOTAL), .SEGMENTS(SEGMENTS)) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_blank            (req_blank),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_frames_per_effect(csr_frames_per_effect),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_desc            (push_desc)
   );

   lspg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_desc (push_desc),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_desc  (pop_desc)
   );

   lspg_back #(.LED_TOTAL(LED_TOTAL), .SEGMENTS(SEGMENTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_desc         (pop_desc),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_index    (rsp_led_index),
      .rsp_color        (rsp_color),
      .rsp_last_led     (rsp_last_led),
      .rsp_active_effect(rsp_active_effect)
   );

endmodule

/* rtl/core/lspg_front.sv */
`timescale 1ns / 1ps

module lspg_front #(
   parameter int LED_TOTAL = 18,
   parameter int SEGMENTS  = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_blank,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [15:0]             csr_frames_per_effect,
   output logic                    push_valid,
   input  logic                    push_ready,
   output lspg_pkg::frame_desc_type push_desc
);
   import lspg_pkg::*;

   localparam logic [IDX_W-1:0] SEG_LEN  = IDX_W'(LED_TOTAL / SEGMENTS);
   localparam logic [POS_W-1:0] LED_ENDS = POS_W'(LED_TOTAL);

   logic [15:0] fpe_ff;
   effect_type  effect_ff, effect_in;
   logic [15:0] frame_cnt_ff, frame_cnt_in;
   logic [2:0]  cycle_idx_ff, cycle_idx_in;
   logic        blink_on_ff, blink_on_in;
   logic [IDX_W-1:0] bounce_pos_ff, bounce_pos_in;
   logic        bounce_fwd_ff, bounce_fwd_in;
   logic [POS_W-1:0] spin_pos_ff, spin_pos_in;
   logic [2:0]  spin_idx_ff, spin_idx_in;
   logic [15:0] frame_cnt_inc;
   logic        take;

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid & push_ready;

   always_comb begin
      push_desc.effect = effect_ff;
      push_desc.paint  = PAINT_FILL;
      push_desc.color  = COLOR_OFF;
      push_desc.pos    = '0;
      if (!req_blank) begin
         case (effect_ff)
            EFFECT_CYCLE: begin
               push_desc.color = palette(cycle_idx_ff);
            end
            EFFECT_BLINK: begin
               push_desc.color = blink_on_ff ? COLOR_WHITE : COLOR_OFF;
            end
            EFFECT_BOUNCE: begin
               push_desc.paint = PAINT_BOUNCE;
               push_desc.color = COLOR_RED;
               push_desc.pos   = {1'b0, bounce_pos_ff};
            end
            default: begin
               push_desc.paint = PAINT_SPIN;
               push_desc.color = palette(spin_idx_ff);
               push_desc.pos   = spin_pos_ff;
            end
         endcase
      end
   end

   always_comb begin
      effect_in     = effect_ff;
      frame_cnt_in  = frame_cnt_ff;
      cycle_idx_in  = cycle_idx_ff;
      blink_on_in   = blink_on_ff;
      bounce_pos_in = bounce_pos_ff;
      bounce_fwd_in = bounce_fwd_ff;
      spin_pos_in   = spin_pos_ff;
      spin_idx_in   = spin_idx_ff;
      frame_cnt_inc = frame_cnt_ff + 16'd1;
      if (take && !req_blank) begin
         case (effect_ff)
            EFFECT_CYCLE: begin
               cycle_idx_in = cycle_idx_ff + 3'd1;
            end
            EFFECT_BLINK: begin
               blink_on_in = ~blink_on_ff;
            end
            EFFECT_BOUNCE: begin
               if (SEG_LEN <= IDX_W'(1)) begin
                  bounce_pos_in = '0;
               end else if (bounce_fwd_ff) begin
                  if ({1'b0, bounce_pos_ff} + 7'd1 >= {1'b0, SEG_LEN}) begin
                     bounce_fwd_in = 1'b0;
                     bounce_pos_in = bounce_pos_ff - IDX_W'(1);
                  end else begin
                     bounce_pos_in = bounce_pos_ff + IDX_W'(1);
                  end
               end else begin
                  if (bounce_pos_ff <= IDX_W'(1)) begin
                     bounce_fwd_in = 1'b1;
                     bounce_pos_in = bounce_pos_ff + IDX_W'(1);
                  end else begin
                     bounce_pos_in = bounce_pos_ff - IDX_W'(1);
                  end
               end
            end
            default: begin
               // one dark frame after the last LED, then restart at the first
               spin_pos_in = (spin_pos_ff >= LED_ENDS) ? '0 : spin_pos_ff + POS_W'(1);
               spin_idx_in = spin_idx_ff + 3'd1;
            end
         endcase
         if (frame_cnt_inc >= fpe_ff) begin
            effect_in    = effect_type'(effect_ff + 2'd1);
            frame_cnt_in = '0;
         end else begin
            frame_cnt_in = frame_cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpe_ff        <= FRAMES_PER_EFFECT_RESET;
         effect_ff     <= EFFECT_CYCLE;
         frame_cnt_ff  <= '0;
         cycle_idx_ff  <= '0;
         blink_on_ff   <= 1'b1;
         bounce_pos_ff <= '0;
         bounce_fwd_ff <= 1'b1;
         spin_pos_ff   <= '0;
         spin_idx_ff   <= '0;
      end else begin
         if (csr_valid) begin
            fpe_ff <= csr_frames_per_effect;
         end
         effect_ff     <= effect_in;
         frame_cnt_ff  <= frame_cnt_in;
         cycle_idx_ff  <= cycle_idx_in;
         blink_on_ff   <= blink_on_in;
         bounce_pos_ff <= bounce_pos_in;
         bounce_fwd_ff <= bounce_fwd_in;
         spin_pos_ff   <= spin_pos_in;
         spin_idx_ff   <= spin_idx_in;
      end
   end

endmodule

/* rtl/core/lspg_queue.sv */
`timescale 1ns / 1ps

module lspg_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  lspg_pkg::frame_desc_type push_desc,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output lspg_pkg::frame_desc_type pop_desc
);
   import lspg_pkg::*;

   frame_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* rtl/core/lspg_back.sv */
`timescale 1ns / 1ps

module lspg_back #(
   parameter int LED_TOTAL = 18,
   parameter int SEGMENTS  = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  lspg_pkg::frame_desc_type pop_desc,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [5:0]               rsp_led_index,
   output logic [23:0]              rsp_color,
   output logic                     rsp_last_led,
   output logic [1:0]               rsp_active_effect
);
   import lspg_pkg::*;

   localparam int K_W = $clog2(SEGMENTS + 1);
   localparam logic [IDX_W-1:0] LAST    = IDX_W'(LED_TOTAL - 1);
   localparam logic [IDX_W-1:0] SEG_LEN = IDX_W'(LED_TOTAL / SEGMENTS);
   localparam logic [K_W-1:0]   SEG_CNT = K_W'(SEGMENTS);

   frame_desc_type   desc_ff, desc_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] led_cnt_ff, led_cnt_in;
   logic [7:0]       next_hit_ff, next_hit_in;
   logic [K_W-1:0]   hits_ff, hits_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [COLOR_W-1:0] rsp_color_ff, color_now;
   logic             rsp_last_ff;
   logic [1:0]       rsp_effect_ff;
   logic             emit, is_last, hit, load;

   assign emit      = busy_ff & (~rsp_valid_ff | rsp_ready);
   assign is_last   = (led_cnt_ff == LAST);
   assign load      = pop_valid & (~busy_ff | (emit & is_last));
   assign pop_ready = ~busy_ff | (emit & is_last);

   // bounce dots sit at pos, pos+L, pos+2L ... walked in LED order
   assign hit = ({2'b00, led_cnt_ff} == next_hit_ff) && (hits_ff < SEG_CNT);

   always_comb begin
      case (desc_ff.paint)
         PAINT_FILL:   color_now = desc_ff.color;
         PAINT_BOUNCE: color_now = hit ? desc_ff.color : COLOR_OFF;
         PAINT_SPIN:   color_now = ({1'b0, led_cnt_ff} == desc_ff.pos) ?
                                   desc_ff.color : COLOR_OFF;
         default:      color_now = COLOR_OFF;
      endcase
   end

   always_comb begin
      desc_in      = desc_ff;
      busy_in      = busy_ff;
      led_cnt_in   = led_cnt_ff;
      next_hit_in  = next_hit_ff;
      hits_in      = hits_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         led_cnt_in   = is_last ? '0 : led_cnt_ff + IDX_W'(1);
         if (hit) begin
            next_hit_in = next_hit_ff + {2'b00, SEG_LEN};
            hits_in     = hits_ff + K_W'(1);
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         desc_in     = pop_desc;
         busy_in     = 1'b1;
         next_hit_in = {1'b0, pop_desc.pos};
         hits_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         led_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         led_cnt_ff   <= led_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      next_hit_ff <= next_hit_in;
      hits_ff     <= hits_in;
      if (emit) begin
         rsp_idx_ff    <= led_cnt_ff;
         rsp_color_ff  <= color_now;
         rsp_last_ff   <= is_last;
         rsp_effect_ff <= desc_ff.effect;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_index     = rsp_idx_ff;
   assign rsp_color         = rsp_color_ff;
   assign rsp_last_led      = rsp_last_ff;
   assign rsp_active_effect = rsp_effect_ff;

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_idx_ff == LAST)
      else $error("last flag on wrong led");

   a_walk: assert property (@(posedge clock) disable iff (reset)
      emit && !is_last |=> led_cnt_ff == $past(led_cnt_ff) + IDX_W'(1))
      else $error("led counter skipped");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> led_cnt_ff == '0)
      else $error("led counter not rewound between frames");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && led_cnt_ff == '0)
      else $error("frame loaded mid-frame");

endmodule

/* tb/sv/led_strip_pattern_generator_test.sv */
`timescale 1ns / 1ps

module led_strip_pattern_generator_test;
   import lspg_pkg::*;

   localparam int LED_TOTAL      = 18;
   localparam int SEGMENTS       = 3;
   localparam int SEG_LEN        = LED_TOTAL / SEGMENTS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CSR_SETTLE     = 4;
   localparam int END_SETTLE     = 2 * LED_TOTAL;
   localparam int PRINT_CAP      = 40;

   typedef struct {
      logic [5:0]  led_index;
      logic [23:0] color;
      logic        last_led;
      logic [1:0]  effect;
   } led_word_type;

   logic        clock;
   logic        reset                 = 1'b1;
   logic        req_valid             = 1'b0;
   logic        req_ready;
   logic        req_blank             = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready             = 1'b0;
   logic [5:0]  rsp_led_index;
   logic [23:0] rsp_color;
   logic        rsp_last_led;
   logic [1:0]  rsp_active_effect;
   logic        csr_valid             = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_frames_per_effect = 16'd0;

   // expected animation state, mirrors the block
   logic [15:0] frames_per_effect = FRAMES_PER_EFFECT_RESET;
   logic [1:0]  fx_sel            = EFFECT_CYCLE;
   logic [15:0] frame_cnt         = 16'd0;
   logic [2:0]  cycle_idx         = 3'd0;
   logic        blink_lit         = 1'b1;
   logic [5:0]  bounce_pos        = 6'd0;
   logic        bounce_fwd        = 1'b1;
   logic [6:0]  spin_pos          = 7'd0;
   logic [2:0]  spin_idx          = 3'd0;

   led_word_type pending_words[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int words_checked = 0;
   int frames_sent   = 0;
   int blanks_sent   = 0;
   int dark_frames   = 0;
   int csr_writes    = 0;
   int quiet_cycles  = 0;
   logic [3:0] effects_drawn = 4'b0000;

   led_strip_pattern_generator #(
      .LED_TOTAL(LED_TOTAL),
      .SEGMENTS (SEGMENTS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_blank            (req_blank),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_led_index        (rsp_led_index),
      .rsp_color            (rsp_color),
      .rsp_last_led         (rsp_last_led),
      .rsp_active_effect    (rsp_active_effect),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_frames_per_effect(csr_frames_per_effect)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [23:0] rainbow_color(input logic [2:0] idx);
      logic [23:0] c;
      case (idx)
         3'd0:    c = 24'hFF0000;
         3'd1:    c = 24'hFF7F00;
         3'd2:    c = 24'hFFFF00;
         3'd3:    c = 24'h00FF00;
         3'd4:    c = 24'h00FFFF;
         3'd5:    c = 24'h0000FF;
         3'd6:    c = 24'h7F007F;
         default: c = 24'hFF007F;
      endcase
      return c;
   endfunction

   // works out the words of one frame and steps the animation state
   function automatic void paint_expected_frame(input logic blank);
      logic [23:0]  pix [LED_TOTAL];
      logic [1:0]   shown;
      int           i;
      int           spot;
      led_word_type w;
      shown = fx_sel;
      for (i = 0; i < LED_TOTAL; i++) pix[i] = COLOR_OFF;
      if (!blank) begin
         effects_drawn[fx_sel] = 1'b1;
         case (fx_sel)
            EFFECT_CYCLE: begin
               for (i = 0; i < LED_TOTAL; i++) pix[i] = rainbow_color(cycle_idx);
               cycle_idx = cycle_idx + 3'd1;
            end
            EFFECT_BLINK: begin
               for (i = 0; i < LED_TOTAL; i++) pix[i] = blink_lit ? COLOR_WHITE : COLOR_OFF;
               blink_lit = !blink_lit;
            end
            EFFECT_BOUNCE: begin
               for (i = 0; i < SEGMENTS; i++) begin
                  spot = int'(bounce_pos) + i * SEG_LEN;
                  if (spot < LED_TOTAL) pix[spot] = COLOR_RED;
               end
               if (SEG_LEN <= 1) begin
                  bounce_pos = 6'd0;
               end else if (bounce_fwd) begin
                  if (int'(bounce_pos) + 1 >= SEG_LEN) begin
                     bounce_fwd = 1'b0;
                     bounce_pos = bounce_pos - 6'd1;
                  end else begin
                     bounce_pos = bounce_pos + 6'd1;
                  end
               end else begin
                  if (bounce_pos <= 6'd1) begin
                     bounce_fwd = 1'b1;
                     bounce_pos = bounce_pos + 6'd1;
                  end else begin
                     bounce_pos = bounce_pos - 6'd1;
                  end
               end
            end
            default: begin
               if (int'(spin_pos) < LED_TOTAL) begin
                  pix[spin_pos] = rainbow_color(spin_idx);
                  spin_pos = spin_pos + 7'd1;
               end else begin
                  // dark frame, dot restarts at the first led
                  dark_frames++;
                  spin_pos = 7'd0;
               end
               spin_idx = spin_idx + 3'd1;
            end
         endcase
         frame_cnt = frame_cnt + 16'd1;
         if (frame_cnt >= frames_per_effect) begin
            fx_sel    = fx_sel + 2'd1;
            frame_cnt = 16'd0;
         end
      end
      for (i = 0; i < LED_TOTAL; i++) begin
         w.led_index = 6'(i);
         w.color     = pix[i];
         w.last_led  = (i == LED_TOTAL - 1);
         w.effect    = shown;
         pending_words.push_back(w);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // response side: random stalls and the check of every beat
   always @(posedge clock) begin
      led_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("beat with no word pending", {26'd0, rsp_led_index}, 32'd0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_led_index !== want.led_index)
               report_mismatch("led_index", {26'd0, rsp_led_index}, {26'd0, want.led_index});
            if (rsp_color !== want.color)
               report_mismatch("color", {8'd0, rsp_color}, {8'd0, want.color});
            if (rsp_last_led !== want.last_led)
               report_mismatch("last_led", {31'd0, rsp_last_led}, {31'd0, want.last_led});
            if (rsp_active_effect !== want.effect)
               report_mismatch("active_effect", {30'd0, rsp_active_effect},
                               {30'd0, want.effect});
         end
         words_checked++;
      end
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("led_strip_pattern_generator_test: done, errors");
      $finish;
   end

   // valid stays up between back-to-back frames; it drops only for a gap
   task automatic send_frame(input logic blank);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_blank <= blank;
      do @(posedge clock); while (!req_ready);
      paint_expected_frame(blank);
      frames_sent++;
      if (blank) blanks_sent++;
   endtask

   task automatic wait_words_done(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_frames_per_effect(input logic [15:0] value);
      wait_words_done(CSR_SETTLE);
      csr_valid             <= 1'b1;
      csr_frames_per_effect <= value;
      do @(posedge clock); while (!csr_ready);
      frames_per_effect = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_frame(1'b0);
      send_frame(1'b0);
      send_frame(1'b1);
   endtask

   // zero behaves as one: every advancing frame hands over to the next effect
   task automatic test_zero_frames();
      int i;
      write_frames_per_effect(16'd0);
      for (i = 0; i < 13; i++) send_frame(i == 6);
   endtask

   task automatic test_one_frame();
      int i;
      write_frames_per_effect(16'd1);
      for (i = 0; i < 4; i++) send_frame(1'b0);
   endtask

   task automatic test_max_frames();
      write_frames_per_effect(16'hFFFF);
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   // mostly advancing frames so bounce turns and spin dark frames are reached
   task automatic test_random_frames(input int n_items, input int s_pct, input int r_pct);
      int i;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_frames_per_effect(16'($urandom_range(1, 6)));
      for (i = 0; i < n_items; i++) begin
         if (i == n_items / 2) write_frames_per_effect(16'($urandom_range(0, 4)));
         send_frame($urandom_range(0, 4) == 0);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 65;
      test_reset_state();
      test_zero_frames();
      test_one_frame();
      test_max_frames();
      test_random_frames(36, 38, 65);
      test_random_frames(36, 65, 38);
      test_random_frames(36, 0, 0);
      wait_words_done(END_SETTLE);
      $display("covered %0d frames (%0d blank), %0d led words, %0d csr writes",
               frames_sent, blanks_sent, words_checked, csr_writes);
      $display("effects drawn %b, spin dark frames %0d", effects_drawn, dark_frames);
      if (error_count == 0) begin
         $display("led_strip_pattern_generator_test: done, clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("led_strip_pattern_generator_test: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/lspg_pkg.sv
rtl/core/lspg_front.sv
rtl/core/lspg_queue.sv
rtl/core/lspg_back.sv
rtl/core/led_strip_pattern_generator.sv
tb/sv/led_strip_pattern_generator_test.sv
